/* rtl/core/ssieve_pkg.sv */
// ----------------------------------------------------------------------------
// Segmented sieve package
// Shared payload types, status codes and controller states.
// ----------------------------------------------------------------------------
package ssieve_pkg;

  localparam int VALUE_BITS  = 20;
  localparam int COUNT_BITS  = 13;
  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REVERSED = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] range_start;
    logic [VALUE_BITS-1:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  prime_count;
    logic [STATUS_BITS-1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_CLEAR,
    ST_SP_READ,
    ST_SP_CHECK,
    ST_SP_MARK,
    ST_SG_READ,
    ST_SG_CHECK,
    ST_SG_DIV,
    ST_SG_MARK,
    ST_CNT_READ,
    ST_CNT_ACC,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/ssieve_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access a cycle: a read, or a write that also reads the old word; read data is registered.
// ----------------------------------------------------------------------------
module ssieve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/ssieve_div.sv */
// ----------------------------------------------------------------------------
// Sieve divider
// Restoring divider, one quotient bit a cycle, for the first multiple search.
// ----------------------------------------------------------------------------
module ssieve_div #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [W:0]    trial;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    rem_nxt = trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], 1'b0};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt    = W'(trial - {1'b0, dvs_r});
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = busy_r && (cnt_r == CW'(1));
  assign quotient = quo_nxt;

endmodule

/* rtl/core/segmented_sieve_prime_count_unit.sv */
// ----------------------------------------------------------------------------
// Segmented sieve prime counter
// Counts the primes in an inclusive range with a two-memory segmented sieve.
// ----------------------------------------------------------------------------
// One job at a time. A job finds the square root, sets both bitmaps over the
// larger of SEG_LEN and ROOT_LIMIT, reads the small map, marks bits, runs a
// first-multiple division for each small prime and reads each counted
// position, all of it bound by the single port of each bitmap memory.
// Reversed or over-long ranges skip the sieve and go straight to the result.
// A finished word waits in the output register while the next job is already
// taken; that job holds its own word until the register is free.
module segmented_sieve_prime_count_unit
  import ssieve_pkg::*;
#(
  parameter int SEG_LEN    = 4096,
  parameter int ROOT_LIMIT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int VB      = VALUE_BITS;
  localparam int SA      = $clog2(SEG_LEN);
  localparam int RA      = $clog2(ROOT_LIMIT);
  localparam int RB      = (VB + 1) / 2 + 1;
  localparam int RCW     = $clog2(VB + 1);
  localparam int CLR_LEN = (SEG_LEN > ROOT_LIMIT) ? SEG_LEN : ROOT_LIMIT;

  state_t state_r, state_nxt;

  logic [VB-1:0]         lo_r, hi_r;
  logic [VB-1:0]         root_r;
  logic [VB-1:0]         p_r;
  logic [2*VB-1:0]       m_r;
  logic [VB:0]           i_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [RCW-1:0]        rstep_r;
  logic                  out_valid_r;
  out_word_t             out_r;

  logic [VB-1:0] lo_in, hi_in;
  assign lo_in = VB'(in_data.range_start);
  assign hi_in = VB'(in_data.range_end);

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // The output register can take a new word when empty or being read.
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Bitmap memories.
  logic          sp_we, sp_wd, sp_rd;
  logic [RA-1:0] sp_addr;
  logic          sg_we, sg_wd, sg_rd;
  logic [SA-1:0] sg_addr;

  ssieve_ram #(.WIDTH(1), .DEPTH(ROOT_LIMIT)) u_small (
    .clk(clk), .we(sp_we), .addr(sp_addr), .wdata(sp_wd), .rdata(sp_rd)
  );
  ssieve_ram #(.WIDTH(1), .DEPTH(SEG_LEN)) u_seg (
    .clk(clk), .we(sg_we), .addr(sg_addr), .wdata(sg_wd), .rdata(sg_rd)
  );

  // First multiple: ceil(lo/p) = (lo + p - 1) / p.
  logic          div_start, div_done;
  logic [VB-1:0] div_q;
  logic [VB:0]   div_q_full;
  logic [VB:0]   div_num;
  assign div_num = {1'b0, lo_r} + {1'b0, p_r} - 1'b1;

  ssieve_div #(.W(VB + 1)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_num), .divisor({1'b0, p_r}), .done(div_done),
    .quotient(div_q_full)
  );
  assign div_q = div_q_full[VB-1:0];

  logic [2*VB-1:0] p_sq;
  logic [2*VB-1:0] first_m;
  logic [2*VB-1:0] q_times_p;
  assign p_sq      = p_r * p_r;
  assign q_times_p = div_q * p_r;
  assign first_m   = (q_times_p < p_sq) ? p_sq : q_times_p;

  // Square root, bit by bit from the top.
  logic [VB-1:0]   root_try;
  logic [2*VB-1:0] root_sq;
  assign root_try = root_r | (VB'(1) << rstep_r);
  assign root_sq  = root_try * root_try;

  logic [VB-1:0] root_sat;
  assign root_sat = (root_r > VB'(ROOT_LIMIT - 1)) ? VB'(ROOT_LIMIT - 1) : root_r;

  logic [VB:0]   span;
  assign span = {1'b0, hi_r} - {1'b0, lo_r};
  logic [VB-1:0] cstart;
  assign cstart = (lo_r > VB'(2)) ? lo_r : VB'(2);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (accept) state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (hi_r < lo_r || span >= (VB+1)'(SEG_LEN)) state_nxt = ST_DONE;
        else if (rstep_r == '0) state_nxt = ST_CLEAR;
      end
      ST_CLEAR:    if (i_r == (VB+1)'(CLR_LEN - 1)) state_nxt = ST_SP_READ;
      ST_SP_READ: begin
        if (p_sq > (2*VB)'(root_sat)) state_nxt = ST_SG_READ;
        else state_nxt = ST_SP_CHECK;
      end
      ST_SP_CHECK: state_nxt = sp_rd ? ST_SP_MARK : ST_SP_READ;
      ST_SP_MARK:  if (m_r + (2*VB)'(p_r) > (2*VB)'(root_sat)) state_nxt = ST_SP_READ;
      ST_SG_READ:  if (p_r > root_sat) state_nxt = ST_CNT_READ; else state_nxt = ST_SG_CHECK;
      ST_SG_CHECK: state_nxt = sp_rd ? ST_SG_DIV : ST_SG_READ;
      ST_SG_DIV:   if (div_done) state_nxt = ST_SG_MARK;
      ST_SG_MARK:  if (m_r > (2*VB)'(hi_r) || m_r + (2*VB)'(p_r) > (2*VB)'(hi_r))
                     state_nxt = ST_SG_READ;
      ST_CNT_READ: if (i_r > (VB+1)'(hi_r)) state_nxt = ST_DONE; else state_nxt = ST_CNT_ACC;
      ST_CNT_ACC:  state_nxt = ST_CNT_READ;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    sp_we = 1'b0; sp_wd = 1'b0; sp_addr = '0;
    sg_we = 1'b0; sg_wd = 1'b0; sg_addr = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        sg_wd   = 1'b1;
        sg_addr = i_r[SA-1:0];
        sg_we   = (i_r < (VB+1)'(SEG_LEN));
        if (i_r < (VB+1)'(ROOT_LIMIT)) begin
          sp_we   = 1'b1;
          sp_wd   = (i_r > (VB+1)'(1)) ? 1'b1 : 1'b0;
          sp_addr = i_r[RA-1:0];
        end
      end
      ST_SP_READ, ST_SG_READ: sp_addr = p_r[RA-1:0];
      ST_SP_MARK: begin
        sp_we = 1'b1; sp_addr = m_r[RA-1:0];
      end
      ST_SG_CHECK: div_start = sp_rd;
      ST_SG_MARK: begin
        sg_we   = (m_r <= (2*VB)'(hi_r));
        sg_addr = SA'(m_r - (2*VB)'(lo_r));
      end
      ST_CNT_READ: sg_addr = SA'(i_r - (VB+1)'(lo_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        lo_r <= lo_in; hi_r <= hi_in; root_r <= '0;
        rstep_r <= RCW'(RB - 1); cnt_r <= '0; i_r <= '0;
      end
      ST_ROOT: begin
        if (root_sq <= (2*VB)'(hi_r)) root_r <= root_try;
        rstep_r <= rstep_r - 1'b1;
        p_r     <= VB'(2);
      end
      ST_CLEAR: i_r <= i_r + 1'b1;
      ST_SP_CHECK: m_r <= p_sq;
      ST_SP_MARK: begin
        m_r <= m_r + (2*VB)'(p_r);
        if (m_r + (2*VB)'(p_r) > (2*VB)'(root_sat)) p_r <= p_r + 1'b1;
      end
      ST_SP_READ: if (state_nxt == ST_SG_READ) p_r <= VB'(2);
      ST_SG_CHECK: if (!sp_rd) p_r <= p_r + 1'b1;
      ST_SG_DIV: m_r <= first_m;
      ST_SG_MARK: begin
        m_r <= m_r + (2*VB)'(p_r);
        if (state_nxt == ST_SG_READ) p_r <= p_r + 1'b1;
      end
      ST_SG_READ: if (state_nxt == ST_CNT_READ) i_r <= {1'b0, cstart};
      ST_CNT_ACC: begin
        cnt_r <= cnt_r + COUNT_BITS'(sg_rd);
        i_r   <= i_r + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          if (hi_r < lo_r) begin
            out_r.prime_count <= '0; out_r.status <= STATUS_REVERSED;
          end else if (span >= (VB+1)'(SEG_LEN)) begin
            out_r.prime_count <= '0; out_r.status <= STATUS_TOO_LONG;
          end else begin
            out_r.prime_count <= cnt_r; out_r.status <= STATUS_OK;
          end
        end
      end
      default: ;
    endcase
    if (state_r == ST_SP_CHECK && !sp_rd) p_r <= p_r + 1'b1;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/ssieve_checker.sv */
// ----------------------------------------------------------------------------
// Segmented sieve port checker
// Watches the ports of the prime counter over time.
// ----------------------------------------------------------------------------
module ssieve_checker
  import ssieve_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second job taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= STATUS_TOO_LONG)
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |-> out_data.prime_count == '0)
    else $error("error word with nonzero count");

endmodule

bind segmented_sieve_prime_count_unit ssieve_checker u_ssieve_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

/* sim/tb_segmented_sieve_prime_count_unit.sv */
// ----------------------------------------------------------------------------
// Segmented sieve prime counter testbench
// Drives range jobs through the valid/stall handshake, predicts each prime
// count and status with a behavioural sieve, and compares result words.
// ----------------------------------------------------------------------------
module tb_segmented_sieve_prime_count_unit;
  import ssieve_pkg::*;

  localparam int SEG_LEN   = 4096;
  localparam int MAX_VALUE = 1048575;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  segmented_sieve_prime_count_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  typedef struct {
    int unsigned lo;
    int unsigned hi;
    bit          typed;
    out_word_t   want;
  } job_row_t;

  out_word_t pending_counts[$];
  int        fail_count;
  int        jobs_sent;
  int        words_seen;
  int        long_ranges;
  int        error_words;
  bit        long_hold_done;

  // Trial division up to the root is enough for a direct primality test.
  function automatic bit divisor_free(int unsigned v);
    int unsigned d;
    if (v < 2) return 0;
    for (d = 2; d * d <= v; d++)
      if (v % d == 0) return 0;
    return 1;
  endfunction

  // Find primes up to floor(sqrt(hi)) by trial division, then strike their multiples in the window.
  function automatic out_word_t count_primes(int unsigned lo, int unsigned hi);
    out_word_t   r;
    bit          window[SEG_LEN];
    int unsigned root;
    int unsigned p;
    int unsigned m;
    int unsigned first;
    int unsigned tally;
    r = '0;
    if (hi < lo) begin
      r.status = STATUS_REVERSED;
      return r;
    end
    if (hi - lo + 1 > SEG_LEN) begin
      r.status = STATUS_TOO_LONG;
      return r;
    end
    root = 0;
    while ((root + 1) * (root + 1) <= hi) root++;
    foreach (window[i]) window[i] = 1;
    for (p = 2; p <= root; p++) begin
      if (!divisor_free(p)) continue;
      first = ((lo + p - 1) / p) * p;
      if (first < p * p) first = p * p;
      for (m = first; m <= hi; m += p) window[m - lo] = 0;
    end
    tally = 0;
    for (m = (lo > 2 ? lo : 2); m <= hi; m++)
      if (window[m - lo]) tally++;
    r.prime_count = tally[COUNT_BITS-1:0];
    r.status      = STATUS_OK;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("tb_segmented_sieve_prime_count_unit failed");
    $finish;
  end

  task automatic send_job(int unsigned lo, int unsigned hi);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.range_start <= lo[19:0];
    in_data.range_end   <= hi[19:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jobs_sent++;
  endtask

  task automatic queue_and_send(int unsigned lo, int unsigned hi, bit typed, out_word_t want);
    out_word_t got;
    got = count_primes(lo, hi);
    if (typed && got !== want) begin
      $error("directed row %0d/%0d: typed %h, predictor %h", lo, hi, want, got);
      fail_count++;
    end
    pending_counts.push_back(typed ? want : got);
    if (got.status != STATUS_OK) error_words++;
    if (hi >= lo && hi - lo + 1 > 1000) long_ranges++;
    send_job(lo, hi);
  endtask

  // Receiver: mostly random stalls, plus one long hold while jobs keep coming.
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && jobs_sent >= 30) begin
        long_hold_done = 1;
        out_stall <= 1'b1;
        for (hold = 0; hold < 60000; hold++) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) < 4) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (pending_counts.size() == 0) begin
        $error("result word with nothing pending: %h", out_data);
        fail_count++;
      end else begin
        want = pending_counts.pop_front();
        if (out_data.prime_count !== want.prime_count) begin
          $error("prime_count expected %0d actual %0d", want.prime_count, out_data.prime_count);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    job_row_t    rows[$];
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int          kind;
    int          wait_cycles;
    fail_count = 0;
    jobs_sent = 0;
    words_seen = 0;
    long_ranges = 0;
    error_words = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{0, 0, 1, '{13'd0, STATUS_OK}},
      '{0, 1, 1, '{13'd0, STATUS_OK}},
      '{2, 2, 1, '{13'd1, STATUS_OK}},
      '{0, 10, 1, '{13'd4, STATUS_OK}},
      '{0, 100, 1, '{13'd25, STATUS_OK}},
      '{5, 4, 1, '{13'd0, STATUS_REVERSED}},
      '{MAX_VALUE, 0, 1, '{13'd0, STATUS_REVERSED}},
      '{0, 4096, 1, '{13'd0, STATUS_TOO_LONG}},
      '{0, MAX_VALUE, 1, '{13'd0, STATUS_TOO_LONG}},
      '{0, 4095, 0, '0},
      '{MAX_VALUE - 4095, MAX_VALUE, 0, '0},
      '{MAX_VALUE, MAX_VALUE, 0, '0},
      '{1048573, 1048573, 0, '0},
      '{1046529, 1046529, 0, '0},
      '{1046528, 1046530, 0, '0},
      '{3, 3, 0, '0},
      '{4, 4, 0, '0},
      '{524288, 528383, 0, '0},
      '{699050, 699050, 0, '0},
      '{349525, 353620, 0, '0}
    };
    foreach (rows[i]) queue_and_send(rows[i].lo, rows[i].hi, rows[i].typed, rows[i].want);

    repeat (80) begin
      kind = $urandom_range(0, 19);
      lo = $urandom_range(0, MAX_VALUE);
      if (kind == 0) begin
        hi = $urandom_range(0, MAX_VALUE);
      end else if (kind == 1) begin
        span = $urandom_range(SEG_LEN, SEG_LEN + 64);
        hi = (lo + span > MAX_VALUE) ? MAX_VALUE : lo + span;
        if (hi - lo + 1 <= SEG_LEN) lo = hi - SEG_LEN;
      end else begin
        // Short windows keep run time down; a few go to the full segment.
        span = (kind < 4) ? $urandom_range(0, SEG_LEN - 1) : $urandom_range(0, 63);
        if (kind == 19) lo = $urandom_range(0, 200);
        hi = (lo + span > MAX_VALUE) ? MAX_VALUE : lo + span;
      end
      queue_and_send(lo, hi, 0, '0);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending_counts.size() != 0 && wait_cycles < 2000000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (30000) @(posedge clk);

    $display("Sent %0d range jobs (%0d error words, %0d wide windows), checked %0d results.",
             jobs_sent, error_words, long_ranges, words_seen);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("tb_segmented_sieve_prime_count_unit passed");
    end else begin
      if (pending_counts.size() != 0)
        $error("%0d results never arrived", pending_counts.size());
      $display("tb_segmented_sieve_prime_count_unit failed");
    end
    $finish;
  end

endmodule
